FILE: rtl/assert_macros.svh
// Assertion macros shared by the receiver RTL.
// ASSERT_CLK expects signals clk and rst_n in the enclosing scope, ASSERT_ALWAYS only clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, ignored while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every rising edge, including reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/pafr_pkg.sv
// Package for the async framing receiver: byte codes, FCS constants, buffer
// sizing and the byte-wide FCS-16 update. No dependencies.
package pafr_pkg;

  // receive buffer
  localparam int BUFFER_DEPTH = 128;
  localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);

  // framing bytes
  localparam logic [7:0] FLAG_BYTE  = 8'h7e;
  localparam logic [7:0] ESC_BYTE   = 8'h7d;
  localparam logic [7:0] ESC_XOR    = 8'h20;
  localparam logic [7:0] START_BYTE = 8'hff;

  // modem text bytes
  localparam logic [7:0] CHAR_CR   = 8'h0d;
  localparam logic [7:0] CHAR_LF   = 8'h0a;
  localparam logic [7:0] CHAR_C    = 8'h43;
  localparam logic [7:0] CHAR_T    = 8'h54;
  localparam logic [7:0] CHAR_PLUS = 8'h2b;
  localparam int         CT_WORD_LEN = 5;

  // FCS-16, reflected polynomial
  localparam logic [15:0] FCS_INIT = 16'hffff;
  localparam logic [15:0] FCS_GOOD = 16'hf0b8;
  localparam logic [15:0] FCS_POLY = 16'h8408;

  // one byte into the FCS, lsb first
  function automatic logic [15:0] fcs_update(input logic [15:0] acc_in,
                                             input logic [7:0]  data);
    logic [15:0] acc;
    acc = acc_in;
    for (int k = 0; k < 8; k++) begin
      if (acc[0] ^ data[k]) begin
        acc = (acc >> 1) ^ FCS_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

FILE: rtl/ppp_async_frame_receiver.sv
// An accepted input item gives its result item in the next cycle.
// Throughput: one item per cycle; the FCS byte update and the framing and
// line decisions settle between the input handshake and the result register.
// Input stalls only while a result is held and the output side stalls.
// Reset (synchronous, rst_n low) clears framing state, FCS, fill count and
// the result valid.
`include "assert_macros.svh"

module ppp_async_frame_receiver
  import pafr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_store_valid,
  output logic [6:0] out_store_index,
  output logic [7:0] out_store_data,
  output logic       out_frame_end,
  output logic       out_frame_good,
  output logic [6:0] out_frame_length,
  output logic       out_line_done,
  output logic [7:0] out_line_length
);

  // decoder state
  logic              esc_pend_r, esc_pend_nxt;
  logic              in_frame_r, in_frame_nxt;
  logic [15:0]       fcs_r, fcs_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [1:0]        plus_run_r, plus_run_nxt;
  logic [7:0]        first_byte_r, first_byte_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic       store_valid_r, store_valid_nxt;
  logic [6:0] store_index_r, store_index_nxt;
  logic [7:0] store_data_r, store_data_nxt;
  logic       frame_end_r, frame_end_nxt;
  logic       frame_good_r, frame_good_nxt;
  logic [6:0] frame_len_r, frame_len_nxt;
  logic       line_done_r, line_done_nxt;
  logic [7:0] line_len_r, line_len_nxt;

  logic accept;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // per-item decode
  always_comb begin
    logic [7:0] b;
    logic       keep;
    logic       line_end;

    b               = in_rx_byte;
    keep            = 1'b1;
    line_end        = 1'b0;
    esc_pend_nxt    = esc_pend_r;
    in_frame_nxt    = in_frame_r;
    fcs_nxt         = fcs_r;
    fill_nxt        = fill_r;
    plus_run_nxt    = plus_run_r;
    first_byte_nxt  = first_byte_r;
    store_valid_nxt = 1'b0;
    store_index_nxt = '0;
    store_data_nxt  = '0;
    frame_end_nxt   = 1'b0;
    frame_good_nxt  = 1'b0;
    frame_len_nxt   = '0;
    line_done_nxt   = 1'b0;
    line_len_nxt    = '0;

    // escape and closing flag
    if (esc_pend_r) begin
      esc_pend_nxt = 1'b0;
      b            = in_rx_byte ^ ESC_XOR;
    end else if (in_rx_byte == ESC_BYTE) begin
      esc_pend_nxt = 1'b1;
      keep         = 1'b0;
    end else if (in_rx_byte == FLAG_BYTE) begin
      if (in_frame_r) begin
        frame_end_nxt = 1'b1;
        if (fcs_r == FCS_GOOD && fill_r > FILL_W'(2)) begin
          frame_good_nxt = 1'b1;
          frame_len_nxt  = 7'(fill_r - FILL_W'(2));
        end
        in_frame_nxt = 1'b0;
      end
      keep     = 1'b0;
      fill_nxt = '0;
    end

    // between frames: frame start, modem lines, +++ escape
    if (!in_frame_nxt) begin
      if (b == START_BYTE) begin
        fcs_nxt      = FCS_INIT;
        fill_nxt     = '0;
        in_frame_nxt = 1'b1;
      end else if (b == CHAR_CR || b == CHAR_LF ||
                   (first_byte_r == CHAR_C && fill_nxt == FILL_W'(CT_WORD_LEN) &&
                    b == CHAR_T)) begin
        line_end = 1'b1;
      end else if (b == CHAR_PLUS) begin
        plus_run_nxt = plus_run_r + 2'd1;
        if (plus_run_r == 2'd2 || plus_run_r == 2'd3) begin
          line_end = 1'b1;
        end
      end else begin
        plus_run_nxt = '0;
      end
      if (line_end) begin
        line_done_nxt = 1'b1;
        line_len_nxt  = 8'(fill_nxt);
        keep          = 1'b0;
        fill_nxt      = '0;
        plus_run_nxt  = '0;
      end
    end

    // FCS and buffer write
    if (keep) begin
      if (in_frame_nxt) begin
        fcs_nxt = fcs_update(fcs_nxt, b);
      end
      if (fill_nxt < FILL_W'(BUFFER_DEPTH)) begin
        if (fill_nxt == '0) begin
          first_byte_nxt = b;
        end
        store_valid_nxt = 1'b1;
        store_index_nxt = 7'(fill_nxt);
        store_data_nxt  = b;
        fill_nxt        = fill_nxt + FILL_W'(1);
      end
    end
  end

  // result valid: set on accept, cleared once taken
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_pend_r   <= 1'b0;
      in_frame_r   <= 1'b0;
      fcs_r        <= '0;
      fill_r       <= '0;
      plus_run_r   <= '0;
      first_byte_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        esc_pend_r   <= esc_pend_nxt;
        in_frame_r   <= in_frame_nxt;
        fcs_r        <= fcs_nxt;
        fill_r       <= fill_nxt;
        plus_run_r   <= plus_run_nxt;
        first_byte_r <= first_byte_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      store_valid_r <= store_valid_nxt;
      store_index_r <= store_index_nxt;
      store_data_r  <= store_data_nxt;
      frame_end_r   <= frame_end_nxt;
      frame_good_r  <= frame_good_nxt;
      frame_len_r   <= frame_len_nxt;
      line_done_r   <= line_done_nxt;
      line_len_r    <= line_len_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_store_valid  = store_valid_r;
  assign out_store_index  = store_index_r;
  assign out_store_data   = store_data_r;
  assign out_frame_end    = frame_end_r;
  assign out_frame_good   = frame_good_r;
  assign out_frame_length = frame_len_r;
  assign out_line_done    = line_done_r;
  assign out_line_length  = line_len_r;

  // checks
  `ASSERT_CLK(a_accept_gives_result, (in_valid && !in_stall) |=> out_valid,
              "accepted item produced no result")
  `ASSERT_CLK(a_good_needs_end, (out_valid && out_frame_good) |-> out_frame_end,
              "good frame reported without frame end")
  `ASSERT_CLK(a_events_exclusive,
              out_valid |-> ($countones({out_store_valid, out_frame_end, out_line_done}) <= 1),
              "store, frame end and line done reported together")
  `ASSERT_ALWAYS(a_no_stall_when_empty, !out_valid |-> !in_stall,
                 "input stalled with no result held")

endmodule

FILE: bench/ppp_async_frame_receiver_test.sv
// Self-checking bench for ppp_async_frame_receiver: framed and escaped bytes,
// FCS-16 frames, modem lines and noise go in; each result item is checked.
// Depends on pafr_pkg and the receiver RTL only.
module ppp_async_frame_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pafr_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int IDLE_PCT     = 19;
  localparam int CALM_FROM    = 700;
  localparam int CALM_TO      = 1000;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_AT     = 1300;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic       store_valid;
    logic [6:0] store_index;
    logic [7:0] store_data;
    logic       frame_end;
    logic       frame_good;
    logic [6:0] frame_length;
    logic       line_done;
    logic [7:0] line_length;
  } rx_result_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic       out_store_valid;
  logic [6:0] out_store_index;
  logic [7:0] out_store_data;
  logic       out_frame_end;
  logic       out_frame_good;
  logic [6:0] out_frame_length;
  logic       out_line_done;
  logic [7:0] out_line_length;

  ppp_async_frame_receiver DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_store_valid  (out_store_valid),
    .out_store_index  (out_store_index),
    .out_store_data   (out_store_data),
    .out_frame_end    (out_frame_end),
    .out_frame_good   (out_frame_good),
    .out_frame_length (out_frame_length),
    .out_line_done    (out_line_done),
    .out_line_length  (out_line_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bytes waiting to be sent, decoded results waiting to come out
  logic [7:0] pending_bytes[$];
  rx_result_t expected_results[$];
  int errors = 0;

  // receiver state as the bench sees it
  logic       esc_armed  = 1'b0;
  logic       frame_open = 1'b0;
  logic [15:0] fcs_acc   = 16'h0000;
  int         fill_cnt   = 0;
  logic [1:0] plus_cnt   = 2'd0;
  logic [7:0] first_byte = 8'h00;

  // reflected FCS-16, one byte, lsb first
  function automatic logic [15:0] fcs16_byte(input logic [15:0] acc_in,
                                             input logic [7:0] data_in);
    logic [15:0] acc;
    logic        fb;
    acc = acc_in;
    for (int k = 0; k < 8; k++) begin
      fb  = acc[0] ^ data_in[k];
      acc = {1'b0, acc[15:1]};
      if (fb) begin
        acc = acc ^ FCS_POLY;
      end
    end
    return acc;
  endfunction

  // one raw byte through the framing, escape and line logic
  function automatic rx_result_t decode_rx_byte(input logic [7:0] raw);
    rx_result_t r;
    logic [7:0] b;
    logic       keep;
    logic       line_end;
    r = '0;
    b = raw;
    keep = 1'b1;
    line_end = 1'b0;
    if (esc_armed) begin
      esc_armed = 1'b0;
      b = raw ^ ESC_XOR;
    end else if (raw == ESC_BYTE) begin
      esc_armed = 1'b1;
      keep = 1'b0;
    end else if (raw == FLAG_BYTE) begin
      if (frame_open) begin
        r.frame_end = 1'b1;
        if (fcs_acc == FCS_GOOD && fill_cnt > 2) begin
          r.frame_good   = 1'b1;
          r.frame_length = 7'(fill_cnt - 2);
        end
        frame_open = 1'b0;
      end
      keep = 1'b0;
      fill_cnt = 0;
    end
    // between frames: start byte, modem line ends, plus escape
    if (!frame_open) begin
      if (b == START_BYTE) begin
        fcs_acc = FCS_INIT;
        fill_cnt = 0;
        frame_open = 1'b1;
      end else if (b == CHAR_CR || b == CHAR_LF ||
                   (first_byte == CHAR_C && fill_cnt == CT_WORD_LEN && b == CHAR_T)) begin
        line_end = 1'b1;
      end else if (b == CHAR_PLUS) begin
        plus_cnt = plus_cnt + 2'd1;
        if (plus_cnt == 2'd3) begin
          line_end = 1'b1;
        end
      end else begin
        plus_cnt = 2'd0;
      end
      if (line_end) begin
        r.line_done   = 1'b1;
        r.line_length = 8'(fill_cnt);
        keep = 1'b0;
        fill_cnt = 0;
        plus_cnt = 2'd0;
      end
    end
    // buffer write, dropped once full; FCS still takes the byte
    if (keep) begin
      if (frame_open) begin
        fcs_acc = fcs16_byte(fcs_acc, b);
      end
      if (fill_cnt < BUFFER_DEPTH) begin
        if (fill_cnt == 0) begin
          first_byte = b;
        end
        r.store_valid = 1'b1;
        r.store_index = 7'(fill_cnt);
        r.store_data  = b;
        fill_cnt++;
      end
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want_v,
                                      input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      errors++;
    end
  endfunction

  // ---- stimulus builders ----
  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
  endtask

  // escape flag and escape bytes, and now and then any other byte
  task automatic push_coded(input logic [7:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE || $urandom_range(0, 15) == 0) begin
      push_byte(ESC_BYTE);
      push_byte(b ^ ESC_XOR);
    end else begin
      push_byte(b);
    end
  endtask

  // mostly short, now and then past the buffer depth
  function automatic int pick_len();
    if ($urandom_range(0, 29) == 0) begin
      return $urandom_range(120, 140);
    end
    return $urandom_range(0, 16);
  endfunction

  // damage: 0 good, 1 one bit flipped, 2 no FCS bytes
  task automatic push_frame(input int len, input int damage);
    logic [15:0] acc;
    logic [7:0]  body[$];
    logic [7:0]  d;
    int          pos;
    acc = fcs16_byte(FCS_INIT, START_BYTE);
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom_range(0, 255));
      body.push_back(d);
      acc = fcs16_byte(acc, d);
    end
    acc = ~acc;
    if (damage != 2) begin
      body.push_back(acc[7:0]);
      body.push_back(acc[15:8]);
    end
    if (damage == 1 && body.size() > 0) begin
      pos = $urandom_range(0, body.size() - 1);
      body[pos] = body[pos] ^ 8'(1 << $urandom_range(0, 7));
    end
    push_byte(FLAG_BYTE);
    if ($urandom_range(0, 7) == 0) begin
      push_byte(ESC_BYTE);
      push_byte(START_BYTE ^ ESC_XOR);
    end else begin
      push_byte(START_BYTE);
    end
    foreach (body[i]) begin
      push_coded(body[i]);
    end
    push_byte(FLAG_BYTE);
  endtask

  // modem text line ended by CR or LF, plain or escaped
  task automatic push_line(input int len);
    if ($urandom_range(0, 1) == 1) begin
      push_byte(FLAG_BYTE);
    end
    for (int i = 0; i < len; i++) begin
      push_byte(8'($urandom_range(8'h30, 8'h5a)));
    end
    case ($urandom_range(0, 3))
      0: push_byte(CHAR_CR);
      1: push_byte(CHAR_LF);
      2: begin
        push_byte(ESC_BYTE);
        push_byte(CHAR_CR ^ ESC_XOR);
      end
      default: begin
        push_byte(ESC_BYTE);
        push_byte(CHAR_LF ^ ESC_XOR);
      end
    endcase
  endtask

  // 'C', four bytes, then 'T' at the sixth position
  task automatic push_ct_word();
    push_byte(FLAG_BYTE);
    push_byte(CHAR_C);
    for (int i = 0; i < 4; i++) begin
      push_byte(8'($urandom_range(8'h30, 8'h5a)));
    end
    push_byte(CHAR_T);
  endtask

  task automatic push_plus_escape();
    int lead;
    lead = $urandom_range(0, 3);
    for (int i = 0; i < lead; i++) begin
      push_byte(8'($urandom_range(8'h30, 8'h5a)));
    end
    repeat (3) push_byte(CHAR_PLUS);
  endtask

  // raw bytes, biased toward the codes the block reacts to
  task automatic push_noise(input int n);
    logic [7:0] specials[9];
    specials = '{FLAG_BYTE, ESC_BYTE, START_BYTE, CHAR_CR, CHAR_LF,
                 CHAR_PLUS, CHAR_C, CHAR_T, 8'h00};
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        push_byte(specials[$urandom_range(0, 8)]);
      end else begin
        push_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---- driver ----
  int   bytes_sent = 0;
  logic drain_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(decode_rx_byte(in_rx_byte));
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        // pause once until every result is out
        if (bytes_sent >= DRAIN_AT && !drain_done && expected_results.size() == 0) begin
          drain_done = 1'b1;
        end
        if (pending_bytes.size() == 0 || (bytes_sent >= DRAIN_AT && !drain_done) ||
            (!(bytes_sent >= CALM_FROM && bytes_sent < CALM_TO) &&
             $urandom_range(0, 99) < IDLE_PCT)) begin
          in_valid <= 1'b0;
        end else begin
          in_valid   <= 1'b1;
          in_rx_byte <= pending_bytes.pop_front();
        end
      end
    end
  end

  // ---- monitor ----
  int         results_seen = 0;
  int         hold_left    = 0;
  logic       hold_done    = 1'b0;
  rx_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result item with no expected item pending");
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("store_valid", 16'(want.store_valid), 16'(out_store_valid));
          check_field("store_index", 16'(want.store_index), 16'(out_store_index));
          check_field("store_data", 16'(want.store_data), 16'(out_store_data));
          check_field("frame_end", 16'(want.frame_end), 16'(out_frame_end));
          check_field("frame_good", 16'(want.frame_good), 16'(out_frame_good));
          check_field("frame_length", 16'(want.frame_length), 16'(out_frame_length));
          check_field("line_done", 16'(want.line_done), 16'(out_line_done));
          check_field("line_length", 16'(want.line_length), 16'(out_line_length));
        end
      end
      // one long hold-off so the input side backs up
      if (hold_left == 0 && !hold_done && results_seen >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (results_seen >= CALM_FROM && results_seen < CALM_TO) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // ---- watchdog: cycles with no item moving ----
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---- stimulus and end of run ----
  initial begin
    logic [7:0] directed[24];
    int         target;
    // line ends, plus escape, escaped CR, escaped flag, flag between frames,
    // C..T word, escaped escape, escaped start, short bad frames
    directed = '{8'h00, CHAR_CR, CHAR_PLUS, CHAR_PLUS, CHAR_PLUS,
                 ESC_BYTE, CHAR_CR ^ ESC_XOR, ESC_BYTE, FLAG_BYTE, FLAG_BYTE,
                 CHAR_C, 8'h41, 8'h42, CHAR_C, 8'h44, CHAR_T,
                 ESC_BYTE, ESC_BYTE, ESC_BYTE, START_BYTE ^ ESC_XOR, FLAG_BYTE,
                 START_BYTE, 8'h80, FLAG_BYTE};
    foreach (directed[i]) begin
      push_byte(directed[i]);
    end
    target = pending_bytes.size() + RANDOM_ITEMS;
    while (pending_bytes.size() < target) begin
      case ($urandom_range(0, 99)) inside
        [0:39]:  push_frame(pick_len(), 0);
        [40:49]: push_frame(pick_len(), $urandom_range(1, 2));
        [50:64]: push_line(pick_len());
        [65:71]: push_ct_word();
        [72:77]: push_plus_escape();
        default: push_noise($urandom_range(1, 6));
      endcase
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
